FILE: hw/rtl/csnc_pkg.sv
// Shared types, codes and constants of the Sobel / non-maximum suppression edge classifier.
// Used by csnc_grad, csnc_nms and canny_sobel_nonmax_classifier_core; no dependencies.
package csnc_pkg;

  localparam int unsigned CSNC_MAX_WIDTH  = 1024;
  localparam int unsigned CSNC_MAX_HEIGHT = 1024;

  localparam int unsigned PIX_W    = 8;
  localparam int unsigned MAG_W    = 21;
  localparam int unsigned GRAD_W   = 11;
  localparam int unsigned THR_SQ_W = 22;
  localparam int unsigned CFG_W    = 11;

  localparam logic [CFG_W-1:0] RST_WIDTH    = 11'd640;
  localparam logic [CFG_W-1:0] RST_HEIGHT   = 11'd480;
  localparam logic [7:0]       RST_LOW_THR  = 8'd10;
  localparam logic [7:0]       RST_HIGH_THR = 8'd30;
  localparam logic [THR_SQ_W-1:0] RST_LOW_SQ  = 22'(64 * 10 * 10);
  localparam logic [THR_SQ_W-1:0] RST_HIGH_SQ = 22'(64 * 30 * 30);

  typedef enum logic [1:0] {
    REG_WIDTH    = 2'd0,
    REG_HEIGHT   = 2'd1,
    REG_LOW_THR  = 2'd2,
    REG_HIGH_THR = 2'd3
  } csnc_reg_e;

  typedef enum logic [1:0] {
    DIR_VERT       = 2'd0,
    DIR_DOWN_RIGHT = 2'd1,
    DIR_HORZ       = 2'd2,
    DIR_UP_RIGHT   = 2'd3
  } csnc_dir_e;

  localparam logic [1:0] CLASS_NONE   = 2'd0;
  localparam logic [1:0] CLASS_WEAK   = 2'd1;
  localparam logic [1:0] CLASS_STRONG = 2'd2;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic             flush;
  } csnc_in_t;

  typedef struct packed {
    logic [1:0]       edge_class;
    logic [1:0]       direction;
    logic [MAG_W-1:0] magnitude_sq;
    logic             last_pixel;
  } csnc_out_t;

  // Border handling of the Sobel window: which neighbor is mirrored.
  typedef struct packed {
    logic left_ref;
    logic right_ref;
    logic top_ref;
    logic bot_ref;
  } csnc_grad_ctrl_t;

  // Which neighbors of the suppression window lie inside the frame, plus result-valid and last flags.
  typedef struct packed {
    logic left_ok;
    logic right_ok;
    logic top_ok;
    logic bot_ok;
    logic res_valid;
    logic last;
  } csnc_nms_ctrl_t;

  typedef struct packed {
    logic [PIX_W-1:0] t;
    logic [PIX_W-1:0] m;
    logic [PIX_W-1:0] b;
  } csnc_pix_col_t;

  typedef struct packed {
    logic [MAG_W-1:0] t;
    logic [MAG_W-1:0] m;
    logic [MAG_W-1:0] b;
    csnc_dir_e        d;
  } csnc_mag_col_t;

endpackage

FILE: hw/rtl/csnc_grad.sv
// Pixel line memory, 3x3 window and Sobel gradient pipeline: magnitude and direction sector.
// Depends on csnc_pkg.
module csnc_grad import csnc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = CSNC_MAX_WIDTH,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  logic [PIX_W-1:0] pixel_i,
  input  logic [AW-1:0]    addr_i,
  input  csnc_grad_ctrl_t  ctrl_i,
  input  csnc_nms_ctrl_t   side_ctrl_i,
  input  logic [AW-1:0]    side_addr_i,
  output logic             valid_o,
  output logic [MAG_W-1:0] mag_o,
  output csnc_dir_e        dir_o,
  output csnc_nms_ctrl_t   side_ctrl_o,
  output logic [AW-1:0]    side_addr_o
);

  // Each entry holds column data of the two previous rows: newer in the upper byte.
  logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [2*PIX_W-1:0] rd_q;

  logic             v1_q, v2_q, v3_q, v4_q;
  logic [PIX_W-1:0] pix1_q;
  logic [AW-1:0]    addr1_q;
  csnc_grad_ctrl_t  ctrl1_q;
  csnc_nms_ctrl_t   sc1_q, sc2_q, sc3_q, sc4_q;
  logic [AW-1:0]    sa1_q, sa2_q, sa3_q, sa4_q;

  csnc_pix_col_t win_a_q, win_b_q, col_new;
  csnc_pix_col_t col_l, col_c, col_r;

  logic signed [GRAD_W-1:0] gx_d, gy_d, gx2_q, gy2_q;

  logic signed [2*GRAD_W-1:0] sqx_full, sqy_full;
  logic [9:0]              ax, ay, dd;
  logic [GRAD_W-1:0]       asum;
  logic [2*GRAD_W-1:0]     s2_d;
  logic [19:0]             dd2_d;
  logic [19:0]             sqx3_q, sqy3_q, dd23_q;
  logic [2*GRAD_W-1:0]     s23_q;
  logic                    gxz3_q, aygt3_q, same3_q;

  logic [MAG_W-1:0] mag_d, two_ax2, mag4_q;
  csnc_dir_e        dir_d, dir4_q;

  function automatic csnc_pix_col_t reflect_rows(csnc_pix_col_t c, logic top_ref, logic bot_ref);
    csnc_pix_col_t r;
    r   = c;
    r.t = top_ref ? c.b : c.t;
    r.b = bot_ref ? c.t : c.b;
    return r;
  endfunction

  function automatic logic [9:0] col_sum(csnc_pix_col_t c);
    return 10'(c.t) + {1'b0, c.m, 1'b0} + 10'(c.b);
  endfunction

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q <= line_mem[addr_i];
      if (v1_q) begin
        line_mem[addr1_q] <= {pix1_q, rd_q[2*PIX_W-1:PIX_W]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else if (en_i) begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  assign col_new.t = rd_q[PIX_W-1:0];
  assign col_new.m = rd_q[2*PIX_W-1:PIX_W];
  assign col_new.b = pix1_q;

  // The window holds the two previous columns; at the first column of a row it still
  // holds the last two columns of the row before, which closes that row's right edge.
  always_comb begin
    col_l = reflect_rows(ctrl1_q.left_ref  ? col_new : win_a_q, ctrl1_q.top_ref, ctrl1_q.bot_ref);
    col_c = reflect_rows(win_b_q, ctrl1_q.top_ref, ctrl1_q.bot_ref);
    col_r = reflect_rows(ctrl1_q.right_ref ? win_a_q : col_new, ctrl1_q.top_ref, ctrl1_q.bot_ref);
    gx_d  = GRAD_W'($signed({1'b0, col_sum(col_r)})) - GRAD_W'($signed({1'b0, col_sum(col_l)}));
    gy_d  = GRAD_W'($signed({1'b0, 10'(col_l.t) + {1'b0, col_c.t, 1'b0} + 10'(col_r.t)}))
          - GRAD_W'($signed({1'b0, 10'(col_l.b) + {1'b0, col_c.b, 1'b0} + 10'(col_r.b)}));
  end

  always_comb begin
    sqx_full = gx2_q * gx2_q;
    sqy_full = gy2_q * gy2_q;
    ax       = gx2_q[GRAD_W-1] ? 10'(-gx2_q) : 10'(gx2_q);
    ay       = gy2_q[GRAD_W-1] ? 10'(-gy2_q) : 10'(gy2_q);
    asum     = GRAD_W'(ax) + GRAD_W'(ay);
    s2_d     = 22'(asum) * 22'(asum);
    dd       = (ay > ax) ? (ay - ax) : 10'd0;
    dd2_d    = 20'(dd) * 20'(dd);
  end

  always_comb begin
    mag_d   = MAG_W'(sqx3_q) + MAG_W'(sqy3_q);
    two_ax2 = {sqx3_q, 1'b0};
    priority if (gxz3_q) begin
      dir_d = DIR_VERT;
    end else if (s23_q < 22'(two_ax2)) begin
      dir_d = DIR_HORZ;
    end else if (aygt3_q && (21'(dd23_q) > two_ax2)) begin
      dir_d = DIR_VERT;
    end else if (same3_q) begin
      dir_d = DIR_UP_RIGHT;
    end else begin
      dir_d = DIR_DOWN_RIGHT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pix1_q  <= pixel_i;
      addr1_q <= addr_i;
      ctrl1_q <= ctrl_i;
      sc1_q   <= side_ctrl_i;
      sa1_q   <= side_addr_i;
      if (v1_q) begin
        win_a_q <= win_b_q;
        win_b_q <= col_new;
      end
      gx2_q   <= gx_d;
      gy2_q   <= gy_d;
      sc2_q   <= sc1_q;
      sa2_q   <= sa1_q;
      sqx3_q  <= sqx_full[19:0];
      sqy3_q  <= sqy_full[19:0];
      s23_q   <= s2_d;
      dd23_q  <= dd2_d;
      gxz3_q  <= (gx2_q == '0);
      aygt3_q <= (ay > ax);
      same3_q <= ((!gx2_q[GRAD_W-1] && gx2_q != '0) == (!gy2_q[GRAD_W-1] && gy2_q != '0));
      sc3_q   <= sc2_q;
      sa3_q   <= sa2_q;
      mag4_q  <= mag_d;
      dir4_q  <= dir_d;
      sc4_q   <= sc3_q;
      sa4_q   <= sa3_q;
    end
  end

  assign valid_o     = v4_q;
  assign mag_o       = mag4_q;
  assign dir_o       = dir4_q;
  assign side_ctrl_o = sc4_q;
  assign side_addr_o = sa4_q;

endmodule

FILE: hw/rtl/csnc_nms.sv
// Magnitude line memory, 3x3 magnitude window, non-maximum suppression and edge classing.
// Depends on csnc_pkg.
module csnc_nms import csnc_pkg::*; #(
  parameter int unsigned MAX_WIDTH = CSNC_MAX_WIDTH,
  localparam int unsigned AW = $clog2(MAX_WIDTH)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                en_i,
  input  logic                valid_i,
  input  logic [MAG_W-1:0]    mag_i,
  input  csnc_dir_e           dir_i,
  input  logic [AW-1:0]       addr_i,
  input  csnc_nms_ctrl_t      ctrl_i,
  input  logic [THR_SQ_W-1:0] lo2_i,
  input  logic [THR_SQ_W-1:0] hi2_i,
  output logic                res_valid_o,
  output csnc_out_t           res_o
);

  // Entry: newer row magnitude, its direction, older row magnitude.
  localparam int unsigned EW = 2 * MAG_W + 2;

  logic [EW-1:0] mag_mem [MAX_WIDTH];
  logic [EW-1:0] rd_q;

  logic             v5_q;
  logic [MAG_W-1:0] mag5_q;
  csnc_dir_e        dir5_q;
  logic [AW-1:0]    addr5_q;
  csnc_nms_ctrl_t   ctrl5_q;

  csnc_mag_col_t    win_a_q, win_b_q, col_new;
  logic [MAG_W-1:0] plus_m, minus_m, ctr_m;
  logic             plus_ok, minus_ok, kept;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rd_q <= mag_mem[addr_i];
      if (v5_q) begin
        mag_mem[addr5_q] <= {mag5_q, dir5_q, rd_q[EW-1:MAG_W+2]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (en_i) begin
      v5_q <= valid_i;
    end
  end

  assign col_new.t = rd_q[MAG_W-1:0];
  assign col_new.m = rd_q[EW-1:MAG_W+2];
  assign col_new.d = csnc_dir_e'(rd_q[MAG_W+1:MAG_W]);
  assign col_new.b = mag5_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag5_q  <= mag_i;
      dir5_q  <= dir_i;
      addr5_q <= addr_i;
      ctrl5_q <= ctrl_i;
      if (v5_q) begin
        win_a_q <= win_b_q;
        win_b_q <= col_new;
      end
    end
  end

  // The pixel under test is the middle of the window; neighbors outside the frame
  // take no part in the comparison.
  always_comb begin
    ctr_m    = win_b_q.m;
    plus_m   = win_b_q.b;
    minus_m  = win_b_q.t;
    plus_ok  = 1'b0;
    minus_ok = 1'b0;
    unique case (win_b_q.d)
      DIR_VERT: begin
        plus_m   = win_b_q.b;
        plus_ok  = ctrl5_q.bot_ok;
        minus_m  = win_b_q.t;
        minus_ok = ctrl5_q.top_ok;
      end
      DIR_DOWN_RIGHT: begin
        plus_m   = col_new.b;
        plus_ok  = ctrl5_q.right_ok && ctrl5_q.bot_ok;
        minus_m  = win_a_q.t;
        minus_ok = ctrl5_q.left_ok && ctrl5_q.top_ok;
      end
      DIR_HORZ: begin
        plus_m   = col_new.m;
        plus_ok  = ctrl5_q.right_ok;
        minus_m  = win_a_q.m;
        minus_ok = ctrl5_q.left_ok;
      end
      DIR_UP_RIGHT: begin
        plus_m   = col_new.t;
        plus_ok  = ctrl5_q.right_ok && ctrl5_q.top_ok;
        minus_m  = win_a_q.b;
        minus_ok = ctrl5_q.left_ok && ctrl5_q.bot_ok;
      end
    endcase
    kept = !(plus_ok && (plus_m > ctr_m)) && !(minus_ok && (minus_m > ctr_m));
  end

  always_comb begin
    res_o.direction    = win_b_q.d;
    res_o.magnitude_sq = ctr_m;
    res_o.last_pixel   = ctrl5_q.last;
    priority if (kept && (THR_SQ_W'(ctr_m) > hi2_i)) begin
      res_o.edge_class = CLASS_STRONG;
    end else if (kept && (THR_SQ_W'(ctr_m) > lo2_i)) begin
      res_o.edge_class = CLASS_WEAK;
    end else begin
      res_o.edge_class = CLASS_NONE;
    end
  end

  assign res_valid_o = v5_q && ctrl5_q.res_valid;

endmodule

FILE: hw/rtl/canny_sobel_nonmax_classifier_core.sv
// Top level of the Sobel / non-maximum suppression edge classifier: position tracking,
// configuration registers and result register. Depends on csnc_pkg, csnc_grad and csnc_nms.
//
// The core takes one grey pixel per clock in raster order while in_stall_o is low and
// returns one classified result per clock once its window has filled, while out_stall_i
// is low; each pixel passes through the gradient pipeline, the suppression register and
// the result register, and each of the two line memories (pixels, then magnitude and
// direction) is read and written back once per pixel. Results lag the input by two rows and
// two pixels: after the last pixel of a frame, send 2*width+2 items (flush or not) to drain
// it. Flush items inside a frame are dropped. Frame geometry is taken when the first item of
// a frame arrives; thresholds act mid-frame. The line memories need no clearing after reset.
module canny_sobel_nonmax_classifier_core import csnc_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = CSNC_MAX_WIDTH,
  parameter int unsigned MAX_HEIGHT = CSNC_MAX_HEIGHT
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  csnc_in_t         in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output csnc_out_t        out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [1:0]       cfg_index_i,
  input  logic [CFG_W-1:0] cfg_data_i
);

  localparam int unsigned AW = $clog2(MAX_WIDTH);
  localparam int unsigned RW = $clog2(MAX_HEIGHT + 3);

  logic [CFG_W-1:0]    cfg_width_q, cfg_height_q;
  logic [7:0]          cfg_low_q, cfg_high_q;
  logic [THR_SQ_W-1:0] lo2_q, hi2_q;
  logic [15:0]         low_sq, high_sq;

  logic [AW-1:0] col_q, wm1_q, wm1_eff, cg;
  logic [RW-1:0] row_q, h_q, h_eff, h_p1, h_p2;
  logic [31:0]   w_ext, h_ext, w_cl, h_cl;
  logic          pos0, accept, push, c_is0, c_is1, c_is2, c_ge2, frame_end;

  csnc_grad_ctrl_t gctrl;
  csnc_nms_ctrl_t  nctrl, nctrl_g;
  logic [AW-1:0]   naddr_g;
  logic            gvalid, res_valid;
  logic [MAG_W-1:0] gmag;
  csnc_dir_e       gdir;
  csnc_out_t       res;

  logic      en, out_valid_q;
  csnc_out_t out_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_width_q  <= RST_WIDTH;
      cfg_height_q <= RST_HEIGHT;
      cfg_low_q    <= RST_LOW_THR;
      cfg_high_q   <= RST_HIGH_THR;
      lo2_q        <= RST_LOW_SQ;
      hi2_q        <= RST_HIGH_SQ;
    end else begin
      lo2_q <= {low_sq, 6'b0};
      hi2_q <= {high_sq, 6'b0};
      if (cfg_valid_i) begin
        unique case (csnc_reg_e'(cfg_index_i))
          REG_WIDTH:    cfg_width_q  <= cfg_data_i;
          REG_HEIGHT:   cfg_height_q <= cfg_data_i;
          REG_LOW_THR:  cfg_low_q    <= cfg_data_i[7:0];
          REG_HIGH_THR: cfg_high_q   <= cfg_data_i[7:0];
        endcase
      end
    end
  end

  assign low_sq  = 16'(cfg_low_q) * 16'(cfg_low_q);
  assign high_sq = 16'(cfg_high_q) * 16'(cfg_high_q);

  always_comb begin
    w_ext = 32'(cfg_width_q);
    h_ext = 32'(cfg_height_q);
    if (w_ext < 32'd3) begin
      w_cl = 32'd3;
    end else if (w_ext > MAX_WIDTH) begin
      w_cl = MAX_WIDTH;
    end else begin
      w_cl = w_ext;
    end
    if (h_ext < 32'd3) begin
      h_cl = 32'd3;
    end else if (h_ext > MAX_HEIGHT) begin
      h_cl = MAX_HEIGHT;
    end else begin
      h_cl = h_ext;
    end
  end

  // Geometry comes from the registers on the first item of a frame, else from the latch.
  assign pos0    = (row_q == '0) && (col_q == '0);
  assign wm1_eff = pos0 ? AW'(w_cl - 32'd1) : wm1_q;
  assign h_eff   = pos0 ? RW'(h_cl) : h_q;
  assign h_p1    = h_eff + RW'(1);
  assign h_p2    = h_eff + RW'(2);

  assign en         = !out_valid_q || !out_stall_i;
  assign in_stall_o = !en;
  assign accept     = in_valid_i && en;
  assign push       = accept && !(in_data_i.flush && (row_q < h_eff));

  assign c_is0     = (col_q == '0);
  assign c_is1     = (col_q == AW'(1));
  assign c_is2     = (col_q == AW'(2));
  assign c_ge2     = !c_is0 && !c_is1;
  assign frame_end = c_is1 && (row_q == h_p2);

  // The gradient center sits one row and one column behind the incoming pixel, the
  // classified pixel one more row and column behind that; at the start of a row both
  // wrap to the end of an earlier row.
  always_comb begin
    gctrl.left_ref  = c_is1;
    gctrl.right_ref = c_is0;
    gctrl.top_ref   = c_is0 ? (row_q == RW'(2)) : (row_q == RW'(1));
    gctrl.bot_ref   = c_is0 ? (row_q == h_p1) : (row_q == h_eff);

    cg              = c_is0 ? wm1_eff : (col_q - AW'(1));
    nctrl.left_ok   = !c_is2;
    nctrl.right_ok  = !c_is1;
    nctrl.top_ok    = c_ge2 ? (row_q != RW'(2)) : (row_q != RW'(3));
    nctrl.bot_ok    = c_ge2 ? (row_q != h_p1) : (row_q != h_p2);
    nctrl.res_valid = c_ge2 ? ((row_q >= RW'(2)) && (row_q <= h_p1))
                            : ((row_q >= RW'(3)) && (row_q <= h_p2));
    nctrl.last      = frame_end;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
      wm1_q <= '0;
      h_q   <= '0;
    end else begin
      if (accept && pos0) begin
        wm1_q <= wm1_eff;
        h_q   <= h_eff;
      end
      if (push) begin
        if (frame_end) begin
          row_q <= '0;
          col_q <= '0;
        end else if (col_q == wm1_eff) begin
          col_q <= '0;
          row_q <= row_q + RW'(1);
        end else begin
          col_q <= col_q + AW'(1);
        end
      end
    end
  end

  csnc_grad #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_grad (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (push),
    .pixel_i     (in_data_i.pixel),
    .addr_i      (col_q),
    .ctrl_i      (gctrl),
    .side_ctrl_i (nctrl),
    .side_addr_i (cg),
    .valid_o     (gvalid),
    .mag_o       (gmag),
    .dir_o       (gdir),
    .side_ctrl_o (nctrl_g),
    .side_addr_o (naddr_g)
  );

  csnc_nms #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_nms (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (en),
    .valid_i     (gvalid),
    .mag_i       (gmag),
    .dir_i       (gdir),
    .addr_i      (naddr_g),
    .ctrl_i      (nctrl_g),
    .lo2_i       (lo2_q),
    .hi2_i       (hi2_q),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= res_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
